### src/assert_macros.svh
// Assertion helpers shared by the RTL. Each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside of reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression that must never be true outside of reset.
`define ASSERT_NEVER(lbl, expr, msg) \
  `ASSERT_CLK(lbl, !(expr), msg)

`endif

### src/bswi_pkg.sv
package bswi_pkg;

  // Command codes of an input transaction.
  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_POP  = 2'd1;
  localparam logic [1:0] CMD_INC  = 2'd2;

  // Status codes of a result transaction.
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Capacity register reset value.
  localparam logic [10:0]    CAP_RESET = 11'd1024;

  // Data returned by a pop on an empty stack.
  localparam logic signed [31:0] EMPTY_POP_DATA = 32'shFFFF_FFFF;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] value;
    logic [10:0]        count;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pop_data;
    logic [1:0]         status;
  } out_item_t;

  // Status of the operation sequencer toward the top level.
  typedef struct packed {
    logic idle;
    logic done;
  } seq_stat_t;

endpackage

### src/bswi_ram.sv
module bswi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one read port with registered read data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/bswi_seq.sv
module bswi_seq #(
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  bswi_pkg::in_item_t       item,
  input  logic [10:0]              max_size,
  input  logic                     out_free,
  output bswi_pkg::seq_stat_t      stat,
  output bswi_pkg::out_item_t      result,
  output logic [$clog2(DEPTH)-1:0] raddr,
  output logic [$clog2(DEPTH)-1:0] waddr,
  output logic                     st_we,
  output logic [31:0]              st_wdata,
  input  logic [31:0]              st_rdata,
  output logic                     inc_we,
  output logic [31:0]              inc_wdata,
  input  logic [31:0]              inc_rdata
);

  localparam int AW = $clog2(DEPTH);
  localparam int SW = $clog2(DEPTH + 1);
  localparam int XW = (SW > 11) ? SW : 11;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_READ = 6'b000010,
    S_POP  = 6'b000100,
    S_PROP = 6'b001000,
    S_INC  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t              state_r, state_nxt;
  logic [SW-1:0]       size_r, size_nxt;
  logic [AW-1:0]       idx_r, idx_nxt;
  logic [1:0]          cmd_r, cmd_nxt;
  logic [31:0]         val_r, val_nxt;
  logic [31:0]         hold_r, hold_nxt;
  bswi_pkg::out_item_t res_r, res_nxt;

  logic [XW-1:0] size_x, max_x, cnt_x, inc_sel, inc_dec;
  logic [SW-1:0] size_dec;
  logic [AW-1:0] top_idx, inc_idx, idx_dec;
  logic          full, empty, inc_none, push_ok;
  logic [31:0]   add_a, add_b, add_y;

  // Fill level checks against the capacity and the storage depth.
  assign size_x   = XW'(size_r);
  assign max_x    = XW'(max_size);
  assign cnt_x    = XW'(item.count);
  assign full     = (size_x >= max_x) || (size_x >= XW'(DEPTH));
  assign empty    = (size_r == '0);
  assign size_dec = size_r - SW'(1);
  assign top_idx  = size_dec[AW-1:0];
  assign idx_dec  = idx_r - AW'(1);

  // An increment lands on the highest entry it covers: min(count, size) - 1.
  assign inc_sel  = (cnt_x < size_x) ? cnt_x : size_x;
  assign inc_dec  = inc_sel - XW'(1);
  assign inc_idx  = inc_dec[AW-1:0];
  assign inc_none = (item.count == '0) || empty;

  assign push_ok  = (state_r == S_IDLE) && start && (item.command == bswi_pkg::CMD_PUSH) &&
                    !full;

  // Shared adder: pop sum, pending-increment carry down, or increment update.
  always_comb begin
    case (state_r)
      S_POP: begin
        add_a = st_rdata;
        add_b = inc_rdata;
      end
      S_PROP: begin
        add_a = hold_r;
        add_b = inc_rdata;
      end
      default: begin
        add_a = inc_rdata;
        add_b = val_r;
      end
    endcase
  end
  assign add_y = add_a + add_b;

  // Memory addressing and write strobes.
  always_comb begin
    case (state_r)
      S_IDLE:  raddr = (item.command == bswi_pkg::CMD_POP) ? top_idx : inc_idx;
      S_POP:   raddr = idx_dec;
      default: raddr = idx_r;
    endcase
  end
  assign waddr     = (state_r == S_IDLE) ? size_r[AW-1:0] : idx_r;
  assign st_we     = push_ok;
  assign st_wdata  = item.value;
  assign inc_we    = push_ok || (state_r == S_PROP) || (state_r == S_INC);
  assign inc_wdata = (state_r == S_IDLE) ? 32'd0 : add_y;

  // Operation sequencer.
  always_comb begin
    state_nxt = state_r;
    size_nxt  = size_r;
    idx_nxt   = idx_r;
    cmd_nxt   = cmd_r;
    val_nxt   = val_r;
    hold_nxt  = hold_r;
    res_nxt   = res_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt   = item.command;
          val_nxt   = item.value;
          res_nxt   = '{pop_data: '0, status: bswi_pkg::ST_DONE};
          state_nxt = S_DONE;
          case (item.command)
            bswi_pkg::CMD_PUSH: begin
              if (full) begin
                res_nxt.status = bswi_pkg::ST_FULL;
              end else begin
                size_nxt = size_r + SW'(1);
              end
            end
            bswi_pkg::CMD_POP: begin
              if (empty) begin
                res_nxt = '{pop_data: bswi_pkg::EMPTY_POP_DATA, status: bswi_pkg::ST_EMPTY};
              end else begin
                size_nxt  = size_dec;
                idx_nxt   = top_idx;
                state_nxt = S_READ;
              end
            end
            bswi_pkg::CMD_INC: begin
              if (!inc_none) begin
                idx_nxt   = inc_idx;
                state_nxt = S_READ;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_READ: begin
        state_nxt = (cmd_r == bswi_pkg::CMD_POP) ? S_POP : S_INC;
      end
      S_POP: begin
        res_nxt.pop_data = add_y;
        hold_nxt         = inc_rdata;
        if (idx_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          idx_nxt   = idx_dec;
          state_nxt = S_PROP;
        end
      end
      S_PROP: begin
        state_nxt = S_DONE;
      end
      S_INC: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      size_r  <= '0;
    end else begin
      state_r <= state_nxt;
      size_r  <= size_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    cmd_r  <= cmd_nxt;
    val_r  <= val_nxt;
    hold_r <= hold_nxt;
    res_r  <= res_nxt;
  end

  assign stat   = '{idle: (state_r == S_IDLE), done: (state_r == S_DONE) && out_free};
  assign result = res_r;

endmodule

### src/bounded_stack_with_bottom_increment.sv
// Channel   Direction  Handshake            Payload
// in_       input      in_valid/in_ready    bswi_pkg::in_item_t
// out_      output     out_valid/out_ready  bswi_pkg::out_item_t
// cfg_      input      cfg_we               cfg_wdata, capacity limit
//
// Push, a no-op, an empty pop and an increment covering no entry end at once; any
// other increment reads, then updates; a pop reads, sums, then carries its pending
// increment down unless it empties the stack. RAM reads are registered; one 32-bit adder is shared.
// Increments are kept as pending amounts per entry, so an increment costs one update.
// Reset (rst_n low, synchronous) empties the stack and sets the capacity to 1024.
// A held result stalls the sequencer in its final step until the output slot frees.
`include "assert_macros.svh"

module bounded_stack_with_bottom_increment #(
  parameter int DEPTH = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bswi_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bswi_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [10:0]         cfg_wdata
);

  localparam int AW = $clog2(DEPTH);

  logic [10:0]         max_size_r;
  logic                out_valid_r;
  bswi_pkg::out_item_t out_data_r;
  bswi_pkg::seq_stat_t stat;
  bswi_pkg::out_item_t result;
  logic                start, out_free;
  logic [AW-1:0]       raddr, waddr;
  logic                st_we, inc_we;
  logic [31:0]         st_wdata, st_rdata, inc_wdata, inc_rdata;

  // Capacity register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_size_r <= bswi_pkg::CAP_RESET;
    end else if (cfg_we) begin
      max_size_r <= cfg_wdata;
    end
  end

  // A transaction is taken only while the sequencer is idle.
  assign in_ready = stat.idle;
  assign start    = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // Output register decouples result delivery from the next transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stat.done) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.done) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  bswi_seq #(
    .DEPTH(DEPTH)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .item     (in_data),
    .max_size (max_size_r),
    .out_free (out_free),
    .stat     (stat),
    .result   (result),
    .raddr    (raddr),
    .waddr    (waddr),
    .st_we    (st_we),
    .st_wdata (st_wdata),
    .st_rdata (st_rdata),
    .inc_we   (inc_we),
    .inc_wdata(inc_wdata),
    .inc_rdata(inc_rdata)
  );

  // Stored words.
  bswi_ram #(
    .WIDTH(32),
    .DEPTH(DEPTH)
  ) u_store_ram (
    .clk  (clk),
    .we   (st_we),
    .waddr(waddr),
    .wdata(st_wdata),
    .raddr(raddr),
    .rdata(st_rdata)
  );

  // Pending increments, one per entry, applying to that entry and all below it.
  bswi_ram #(
    .WIDTH(32),
    .DEPTH(DEPTH)
  ) u_inc_ram (
    .clk  (clk),
    .we   (inc_we),
    .waddr(waddr),
    .wdata(inc_wdata),
    .raddr(raddr),
    .rdata(inc_rdata)
  );

  // Assertions.
  `ASSERT_CLK(a_busy_after_accept, (in_valid && in_ready) |=> !in_ready,
              "sequencer still idle after accepting a transaction")
  `ASSERT_NEVER(a_no_overwrite, stat.done && out_valid_r && !out_ready,
                "result completed while the output register was still held")
  `ASSERT_CLK(a_valid_from_done, $rose(out_valid_r) |-> $past(stat.done),
              "output became valid without a completed operation")

endmodule

### bench/bswi_checker.sv
module bswi_checker #(
  parameter int DEPTH = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  bswi_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  bswi_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [10:0]         cfg_wdata,
  output int                  fail_count,
  output int                  outstanding
);

  // Shadow copy of the stack, its fill level and the capacity register.
  logic signed [31:0] stack_words [DEPTH];
  int unsigned        fill_level;
  logic [10:0]        capacity_reg;

  // Replies predicted for accepted commands, oldest first.
  bswi_pkg::out_item_t stack_replies [$];

  // Applies one command to the shadow stack and returns the reply it must produce.
  function automatic bswi_pkg::out_item_t run_stack_op(bswi_pkg::in_item_t op);
    bswi_pkg::out_item_t reply;
    int unsigned         limit;
    int unsigned         span;
    int unsigned         j;
    reply.pop_data = '0;
    reply.status   = bswi_pkg::ST_DONE;
    limit = (capacity_reg > DEPTH) ? DEPTH : capacity_reg;
    case (op.command)
      bswi_pkg::CMD_PUSH: begin
        if (fill_level >= limit) begin
          reply.status = bswi_pkg::ST_FULL;
        end else begin
          stack_words[fill_level] = op.value;
          fill_level++;
        end
      end
      bswi_pkg::CMD_POP: begin
        if (fill_level == 0) begin
          reply.pop_data = bswi_pkg::EMPTY_POP_DATA;
          reply.status   = bswi_pkg::ST_EMPTY;
        end else begin
          fill_level--;
          reply.pop_data = stack_words[fill_level];
        end
      end
      bswi_pkg::CMD_INC: begin
        // The count is clamped to the fill level; sums wrap at 32 bits.
        span = (op.count < fill_level) ? op.count : fill_level;
        if (span > DEPTH) span = DEPTH;
        for (j = 0; j < span; j++) begin
          stack_words[j] = stack_words[j] + op.value;
        end
      end
      default: begin
        // The unused command leaves the stack alone and reports done.
      end
    endcase
    return reply;
  endfunction

  // Compare each result transaction with the oldest prediction, then record new commands.
  always @(posedge clk) begin : monitor
    bswi_pkg::out_item_t want;
    int                  errs;
    errs = 0;
    if (!rst_n) begin
      fill_level   = 0;
      capacity_reg = bswi_pkg::CAP_RESET;
      stack_replies.delete();
      fail_count  <= 0;
      outstanding <= 0;
    end else begin
      if (cfg_we) begin
        capacity_reg = cfg_wdata;
      end
      if (out_valid && out_ready) begin
        if (stack_replies.size() == 0) begin
          $error("unexpected result transaction: pop_data %0d, status %0d",
                 out_data.pop_data, out_data.status);
          errs++;
        end else begin
          want = stack_replies.pop_front();
          if (out_data.pop_data !== want.pop_data) begin
            $error("pop_data: expected %0d, actual %0d", want.pop_data, out_data.pop_data);
            errs++;
          end
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_data.status);
            errs++;
          end
        end
      end
      if (in_valid && in_ready) begin
        stack_replies = {stack_replies, run_stack_op(in_data)};
      end
      fail_count  <= fail_count + errs;
      outstanding <= stack_replies.size();
    end
  end

endmodule

### bench/tb.sv
module tb;

  localparam logic [1:0] CMD_NOP     = 2'd3;
  localparam int         MAX_GAP     = 13;
  localparam int         STALL_LIMIT = 4000;
  localparam int         TAIL_CYCLES = 8;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  bswi_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  bswi_pkg::out_item_t out_data;
  logic                cfg_we = 1'b0;
  logic [10:0]         cfg_wdata = '0;
  int                  fail_count;
  int                  outstanding;
  int                  quiet_cycles = 0;
  bit                  tx_steady = 1'b0;
  bit                  rx_steady = 1'b0;

  bounded_stack_with_bottom_increment DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  bswi_checker stack_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // Clock with a period of 8.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // End the run if no transaction moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("bounded_stack_with_bottom_increment: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: stall a random number of cycles before taking each transaction.
  initial begin : drain_results
    int unsigned gap;
    forever begin
      gap = rx_steady ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Offers one command after a random gap and holds it until it is accepted.
  task automatic send_op(input logic [1:0] cmd, input logic [31:0] val,
                         input logic [10:0] cnt);
    int unsigned        gap;
    bswi_pkg::in_item_t op;
    gap = tx_steady ? 0 : $urandom_range(0, MAX_GAP);
    op.command = cmd;
    op.value   = val;
    op.count   = cnt;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= op;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stops sending and waits until every predicted reply has come back.
  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Writes the capacity limit once the block is idle and picks new idling modes.
  task automatic set_capacity(input logic [10:0] cap);
    quiesce();
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we    <= 1'b0;
    tx_steady = ($urandom_range(0, 3) == 0);
    rx_steady = ($urandom_range(0, 3) == 0);
  endtask

  // Data words lean toward the signed extremes now and then.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0001;
      default: return $urandom();
    endcase
  endfunction

  // Increment counts are mostly small (0 to 12), sometimes zero, the maximum or anywhere in range.
  function automatic logic [10:0] pick_count();
    case ($urandom_range(0, 9))
      0: return 11'd0;
      1: return 11'h7FF;
      2, 3: return 11'($urandom_range(0, 2047));
      default: return 11'($urandom_range(0, 12));
    endcase
  endfunction

  // Sends n random commands with the given percentages of push, pop and increment.
  task automatic random_ops(input int n, input int push_w, input int pop_w, input int inc_w);
    int         pick;
    logic [1:0] cmd;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < push_w) cmd = bswi_pkg::CMD_PUSH;
      else if (pick < push_w + pop_w) cmd = bswi_pkg::CMD_POP;
      else if (pick < push_w + pop_w + inc_w) cmd = bswi_pkg::CMD_INC;
      else cmd = CMD_NOP;
      send_op(cmd, pick_value(), pick_count());
    end
  endtask

  initial begin
    logic [10:0] cap;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty stack, extreme words, wrapping sums, zero and oversized counts.
    send_op(bswi_pkg::CMD_POP, 32'd0, 11'd0);
    send_op(bswi_pkg::CMD_INC, 32'd7, 11'h7FF);
    send_op(bswi_pkg::CMD_PUSH, 32'h7FFF_FFFF, 11'd0);
    send_op(bswi_pkg::CMD_PUSH, 32'h8000_0000, 11'h7FF);
    send_op(bswi_pkg::CMD_PUSH, 32'hFFFF_FFFF, 11'd0);
    send_op(bswi_pkg::CMD_INC, 32'd1, 11'd2);
    send_op(bswi_pkg::CMD_INC, 32'd5, 11'd0);
    send_op(bswi_pkg::CMD_INC, 32'h8000_0000, 11'h7FF);
    send_op(CMD_NOP, 32'hFFFF_FFFF, 11'h7FF);
    send_op(bswi_pkg::CMD_POP, 32'd0, 11'd0);
    send_op(bswi_pkg::CMD_POP, 32'd0, 11'd0);
    send_op(bswi_pkg::CMD_POP, 32'd0, 11'd0);
    send_op(bswi_pkg::CMD_POP, 32'd0, 11'd0);

    // A capacity of zero drops every push.
    set_capacity(11'd0);
    send_op(bswi_pkg::CMD_PUSH, 32'd1, 11'd0);
    send_op(bswi_pkg::CMD_POP, 32'd0, 11'd0);

    // Capacity one, then lowered below the fill level.
    set_capacity(11'd1);
    send_op(bswi_pkg::CMD_PUSH, 32'd9, 11'd0);
    send_op(bswi_pkg::CMD_PUSH, 32'd10, 11'd0);
    send_op(bswi_pkg::CMD_INC, 32'hFFFF_FFFD, 11'd1);
    set_capacity(11'd4);
    send_op(bswi_pkg::CMD_PUSH, 32'd11, 11'd0);
    send_op(bswi_pkg::CMD_PUSH, 32'd12, 11'd0);
    set_capacity(11'd1);
    send_op(bswi_pkg::CMD_PUSH, 32'd13, 11'd0);
    send_op(bswi_pkg::CMD_POP, 32'd0, 11'd0);
    send_op(bswi_pkg::CMD_POP, 32'd0, 11'd0);

    // Short phases with small capacities, where full and empty come up often.
    repeat (10) begin
      case ($urandom_range(0, 5))
        0: cap = 11'd0;
        1: cap = 11'd1;
        2: cap = 11'h7FF;
        default: cap = 11'($urandom_range(2, 24));
      endcase
      set_capacity(cap);
      random_ops($urandom_range(8, 20), 40, 35, 20);
    end

    // Fill the whole store past the limit of the memory, then work at the top.
    set_capacity(11'h7FF);
    random_ops(1060, 99, 0, 1);
    random_ops(40, 50, 25, 25);

    // Capacity far below a deep fill level, then the reset capacity again.
    set_capacity(11'($urandom_range(100, 900)));
    random_ops(40, 45, 35, 15);
    set_capacity(11'd1024);
    random_ops(30, 60, 20, 15);

    quiesce();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("bounded_stack_with_bottom_increment: match");
    end else begin
      $display("bounded_stack_with_bottom_increment: mismatch");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+src
src/bswi_pkg.sv
src/bswi_ram.sv
src/bswi_seq.sv
src/bounded_stack_with_bottom_increment.sv
bench/bswi_checker.sv
bench/tb.sv
